// ----- rtl/esup_pkg.sv -----
// Shared types and constants for the emergency-stop supervisor.
`timescale 1ns / 1ps

package esup_pkg;

    localparam int CFG_W          = 13;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 5;
    localparam int NUM_AXES       = 5;
    localparam int SPINDLE_CODE_W = 32;
    localparam int TIMER_CAP_DEF  = 6000;

    localparam logic [CFG_W-1:0] STARTUP_WAIT_RST     = 13'd3000;
    localparam logic [CFG_W-1:0] RESET_WAIT_RST       = 13'd1000;
    localparam logic [CFG_W-1:0] MOTOR_OFF_TIME_RST   = 13'd100;
    localparam logic [CFG_W-1:0] MACHINE_ON_DELAY_RST = 13'd1100;
    localparam logic [CFG_W-1:0] UNHOME_DELAY_RST     = 13'd100;

    typedef enum logic [2:0] {
        REG_STARTUP_WAIT     = 3'd0,
        REG_RESET_WAIT       = 3'd1,
        REG_MOTOR_OFF_TIME   = 3'd2,
        REG_MACHINE_ON_DELAY = 3'd3,
        REG_UNHOME_DELAY     = 3'd4
    } esup_reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] startup_wait;
        logic [CFG_W-1:0] reset_wait;
        logic [CFG_W-1:0] motor_off_time;
        logic [CFG_W-1:0] machine_on_delay;
        logic [CFG_W-1:0] unhome_delay;
    } esup_cfg_t;

    typedef struct packed {
        logic [NUM_AXES-1:0]              axis_fault;
        logic [NUM_AXES-1:0]              follow_error;
        logic                             button_pressed;
        logic signed [SPINDLE_CODE_W-1:0] spindle_error_code;
        logic                             link_ok;
        logic                             ignore_comm_errors;
        logic                             user_reset_request;
        logic                             user_enable_in;
    } esup_item_t;

    typedef struct packed {
        logic run_enable;
        logic machine_on;
        logic motor_enable;
        logic unhome;
        logic reset_pending;
    } esup_res_t;

endpackage

// ----- rtl/esup_ifs.sv -----
// Input and result word channels of the emergency-stop supervisor.
`timescale 1ns / 1ps

interface esup_in_if
    import esup_pkg::*;
();
    logic                             valid;
    logic                             ready;
    logic [NUM_AXES-1:0]              axis_fault;
    logic [NUM_AXES-1:0]              follow_error;
    logic                             button_pressed;
    logic signed [SPINDLE_CODE_W-1:0] spindle_error_code;
    logic                             link_ok;
    logic                             ignore_comm_errors;
    logic                             user_reset_request;
    logic                             user_enable_in;

    modport source (
        output valid, axis_fault, follow_error, button_pressed, spindle_error_code,
               link_ok, ignore_comm_errors, user_reset_request, user_enable_in,
        input  ready
    );
    modport sink (
        input  valid, axis_fault, follow_error, button_pressed, spindle_error_code,
               link_ok, ignore_comm_errors, user_reset_request, user_enable_in,
        output ready
    );
endinterface

interface esup_out_if;
    logic valid;
    logic ready;
    logic run_enable;
    logic machine_on;
    logic motor_enable;
    logic unhome;
    logic reset_pending;

    modport source (
        output valid, run_enable, machine_on, motor_enable, unhome, reset_pending,
        input  ready
    );
    modport sink (
        input  valid, run_enable, machine_on, motor_enable, unhome, reset_pending,
        output ready
    );
endinterface

// ----- rtl/esup_cfg.sv -----
// APB register file holding the supervisor timing registers.
`timescale 1ns / 1ps

module esup_cfg
    import esup_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output esup_cfg_t             cfg
);

    esup_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic [CFG_W-1:0] wdata;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wdata   = pwdata[CFG_W-1:0];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_wait     <= STARTUP_WAIT_RST;
            cfg_reg.reset_wait       <= RESET_WAIT_RST;
            cfg_reg.motor_off_time   <= MOTOR_OFF_TIME_RST;
            cfg_reg.machine_on_delay <= MACHINE_ON_DELAY_RST;
            cfg_reg.unhome_delay     <= UNHOME_DELAY_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_STARTUP_WAIT:     cfg_reg.startup_wait     <= wdata;
                REG_RESET_WAIT:       cfg_reg.reset_wait       <= wdata;
                REG_MOTOR_OFF_TIME:   cfg_reg.motor_off_time   <= wdata;
                REG_MACHINE_ON_DELAY: cfg_reg.machine_on_delay <= wdata;
                REG_UNHOME_DELAY:     cfg_reg.unhome_delay     <= wdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_STARTUP_WAIT:     prdata = APB_DATA_W'(cfg_reg.startup_wait);
            REG_RESET_WAIT:       prdata = APB_DATA_W'(cfg_reg.reset_wait);
            REG_MOTOR_OFF_TIME:   prdata = APB_DATA_W'(cfg_reg.motor_off_time);
            REG_MACHINE_ON_DELAY: prdata = APB_DATA_W'(cfg_reg.machine_on_delay);
            REG_UNHOME_DELAY:     prdata = APB_DATA_W'(cfg_reg.unhome_delay);
            default:              prdata = '0;
        endcase
    end

endmodule

// ----- rtl/esup_core.sv -----
// Supervisor state, fault latches, timers and result register.
`timescale 1ns / 1ps

module esup_core
    import esup_pkg::*;
#(
    parameter int TIMER_CAP = TIMER_CAP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  esup_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  esup_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output esup_res_t  out_res
);

    localparam int TW = $clog2(TIMER_CAP + 2);
    localparam int CW = (TW > CFG_W) ? TW : CFG_W;
    localparam logic [TW-1:0] TCAP = TW'(TIMER_CAP);

    // input stage
    logic       s1_valid_reg;
    esup_item_t s1_item_reg;
    logic       out_valid_reg;
    esup_res_t  res_reg, res_next;
    logic       advance;

    // supervisor state
    logic [NUM_AXES-1:0] mfl_reg, mfl_next;
    logic [NUM_AXES-1:0] fel_reg, fel_next;
    logic sel_reg, sel_next;
    logic lel_reg, lel_next;
    logic pushed_reg, pushed_next;
    logic released_reg, released_next;
    logic estop_reg, estop_next;
    logic rst_lat_reg, rst_lat_next;
    logic motors_reg, motors_next;
    logic [TW-1:0] t_req_reg, t_req_next;
    logic [TW-1:0] t_estop_reg, t_estop_next;
    logic [TW-1:0] t_start_reg, t_start_next;
    logic [TW-1:0] t_rel_reg, t_rel_next;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        logic                ign, btn, sp, lok, req, uen;
        logic [NUM_AXES-1:0] af, fe;
        logic                old_any, guard, rel_evt, fault, start_rst, clr, estop;
        logic [TW-1:0]       t_rel1, t_req1;
        logic [CW-1:0]       sw, rw, mot, mod, ud;

        sw  = CW'(cfg.startup_wait);
        rw  = CW'(cfg.reset_wait);
        mot = CW'(cfg.motor_off_time);
        mod = CW'(cfg.machine_on_delay);
        ud  = CW'(cfg.unhome_delay);

        ign = s1_item_reg.ignore_comm_errors;
        af  = ign ? '0 : s1_item_reg.axis_fault;
        fe  = s1_item_reg.follow_error;
        btn = s1_item_reg.button_pressed;
        sp  = (|s1_item_reg.spindle_error_code) && !ign;
        lok = s1_item_reg.link_ok || ign;
        req = s1_item_reg.user_reset_request;
        uen = s1_item_reg.user_enable_in;

        old_any = (|mfl_reg) || (|fel_reg) || sel_reg || lel_reg || pushed_reg;
        guard   = !btn && !pushed_reg && (CW'(t_start_reg) > sw)
                  && (CW'(t_req_reg) > rw) && (CW'(t_rel_reg) > sw);

        mfl_next = mfl_reg | (guard ? af : '0);
        sel_next = sel_reg | (guard && sp);
        lel_next = lel_reg | (guard && !lok);
        fel_next = fel_reg | fe;

        pushed_next   = pushed_reg | btn;
        rel_evt       = pushed_reg && !btn;
        t_rel1        = (rel_evt && !released_reg) ? '0 : t_rel_reg;
        released_next = released_reg | rel_evt;

        fault = (|af) || (|fe) || !lok || sp || btn;

        start_rst    = !rst_lat_reg && (req || (released_next && (CW'(t_rel1) > sw)));
        rst_lat_next = rst_lat_reg | start_rst;
        t_req1       = start_rst ? '0 : t_req_reg;

        motors_next = motors_reg;
        estop_next  = estop_reg;
        clr         = 1'b0;
        if (rst_lat_next)
        begin
            motors_next = CW'(t_req1) >= mot;
            clr         = CW'(t_req1) > rw;
        end
        if (clr)
        begin
            mfl_next      = '0;
            fel_next      = '0;
            sel_next      = 1'b0;
            lel_next      = 1'b0;
            pushed_next   = 1'b0;
            released_next = 1'b0;
            estop_next    = 1'b0;
            rst_lat_next  = 1'b0;
        end

        t_rel_next   = (t_rel1 <= TCAP) ? t_rel1 + TW'(1) : t_rel1;
        t_req_next   = (t_req1 <= TCAP) ? t_req1 + TW'(1) : t_req1;
        t_start_next = (t_start_reg <= TCAP) ? t_start_reg + TW'(1) : t_start_reg;
        t_estop_next = (t_estop_reg <= TCAP) ? t_estop_reg + TW'(1) : t_estop_reg;

        estop = !(!fault && uen && (!old_any || clr));
        if (estop && !estop_next)
        begin
            t_estop_next = '0;
            estop_next   = 1'b1;
        end

        res_next.run_enable    = !estop;
        res_next.machine_on    = !estop && (CW'(t_req_next) > mod);
        res_next.motor_enable  = motors_next;
        res_next.unhome        = estop_reg && (CW'(t_estop_reg) > ud);
        res_next.reset_pending = rst_lat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mfl_reg       <= '0;
            fel_reg       <= '0;
            sel_reg       <= 1'b0;
            lel_reg       <= 1'b0;
            pushed_reg    <= 1'b0;
            released_reg  <= 1'b0;
            estop_reg     <= 1'b0;
            rst_lat_reg   <= 1'b0;
            motors_reg    <= 1'b1;
            t_req_reg     <= '0;
            t_estop_reg   <= '0;
            t_start_reg   <= '0;
            t_rel_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mfl_reg       <= mfl_next;
                fel_reg       <= fel_next;
                sel_reg       <= sel_next;
                lel_reg       <= lel_next;
                pushed_reg    <= pushed_next;
                released_reg  <= released_next;
                estop_reg     <= estop_next;
                rst_lat_reg   <= rst_lat_next;
                motors_reg    <= motors_next;
                t_req_reg     <= t_req_next;
                t_estop_reg   <= t_estop_next;
                t_start_reg   <= t_start_next;
                t_rel_reg     <= t_rel_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_item;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- rtl/estop_safety_supervisor.sv -----
// Top level of the emergency-stop supervisor for a five-axis machine.
//
// One input word per servo tick on in_ch (valid/ready): fault bits, following
// errors, button, spindle code, link state and the user reset/enable signals.
// One result word per input word on out_ch: run enable, machine-on, motor
// enable, unhome and reset pending.
// Timing registers sit on the APB port, byte address 4*i; write them only
// while no word is in flight. pready is tied high.
// A word taken from in_ch lands in the input register; its result is then
// registered and offered on out_ch once the result register is free or read.
// Throughput: one word per cycle while out_ch.ready holds, set by the single
// state-update pass between the input and result registers.
// Reset: fault latches clear, motors enabled, all tick timers at zero,
// registers at their defaults.
// A stalled receiver holds the result word; one more input word is taken
// into the input register, then in_ch.ready drops until the result goes.
`timescale 1ns / 1ps

module estop_safety_supervisor
    import esup_pkg::*;
#(
    parameter int TIMER_CAP = TIMER_CAP_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    esup_in_if.sink               in_ch,
    esup_out_if.source            out_ch
);

    esup_cfg_t  cfg;
    esup_item_t item;
    esup_res_t  res;

    esup_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item.axis_fault         = in_ch.axis_fault;
    assign item.follow_error       = in_ch.follow_error;
    assign item.button_pressed     = in_ch.button_pressed;
    assign item.spindle_error_code = in_ch.spindle_error_code;
    assign item.link_ok            = in_ch.link_ok;
    assign item.ignore_comm_errors = in_ch.ignore_comm_errors;
    assign item.user_reset_request = in_ch.user_reset_request;
    assign item.user_enable_in     = in_ch.user_enable_in;

    esup_core #(
        .TIMER_CAP (TIMER_CAP)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (item),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (res)
    );

    assign out_ch.run_enable    = res.run_enable;
    assign out_ch.machine_on    = res.machine_on;
    assign out_ch.motor_enable  = res.motor_enable;
    assign out_ch.unhome        = res.unhome;
    assign out_ch.reset_pending = res.reset_pending;

endmodule
